### rtl/pidaw_pkg.sv
// Shared constants, operation codes and controller/datapath types for the PID core.
package pidaw_pkg;

	localparam int WORD_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int DT_W      = 16;
	localparam int DT_FRAC   = 16;
	localparam int ACC_W     = 64;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int WIDE_W    = PROD_W + WORD_W;
	localparam int MAG_W     = WIDE_W - FRAC_W;
	localparam int DIV_W     = WORD_W + FRAC_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int CFG_IDX_W = 3;
	localparam int OP_W      = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH = 3'd4;

	localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 5'd2;
	localparam logic [OP_W-1:0] OP_ERR    = 5'd3;
	localparam logic [OP_W-1:0] OP_MUL_P  = 5'd4;
	localparam logic [OP_W-1:0] OP_P      = 5'd5;
	localparam logic [OP_W-1:0] OP_MUL_E  = 5'd6;
	localparam logic [OP_W-1:0] OP_ACC    = 5'd7;
	localparam logic [OP_W-1:0] OP_MUL_IL = 5'd8;
	localparam logic [OP_W-1:0] OP_MUL_IH = 5'd9;
	localparam logic [OP_W-1:0] OP_IRAW   = 5'd10;
	localparam logic [OP_W-1:0] OP_ICLAMP = 5'd11;
	localparam logic [OP_W-1:0] OP_DIV    = 5'd12;
	localparam logic [OP_W-1:0] OP_BC_WB  = 5'd13;
	localparam logic [OP_W-1:0] OP_DIFF   = 5'd14;
	localparam logic [OP_W-1:0] OP_MUL_D  = 5'd15;
	localparam logic [OP_W-1:0] OP_T      = 5'd16;
	localparam logic [OP_W-1:0] OP_DLOAD  = 5'd17;
	localparam logic [OP_W-1:0] OP_D      = 5'd18;
	localparam logic [OP_W-1:0] OP_SUM    = 5'd19;
	localparam logic [OP_W-1:0] OP_SKIP   = 5'd20;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_req;
		logic dt_zero;
		logic bc_need;
		logic div_done;
	} dp_stat_t;

endpackage

### rtl/pidaw_if.sv
// Request and response channel interfaces of the PID core.
interface pidaw_req_if;
	import pidaw_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [WORD_W-1:0] target;
	logic [WORD_W-1:0] sensed;
	logic [DT_W-1:0]   step_time;
	modport source (output valid, req_type, target, sensed, step_time, input ready);
	modport sink (input valid, req_type, target, sensed, step_time, output ready);
endinterface

interface pidaw_rsp_if;
	import pidaw_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] drive;
	logic              skipped;
	modport source (output valid, drive, skipped, input ready);
	modport sink (input valid, drive, skipped, output ready);
endinterface

### rtl/pidaw_dp.sv
// Datapath: config registers, state, shared multiplier, serial divider, output register.
module pidaw_dp
	import pidaw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 in_req_type,
	input  logic [WORD_W-1:0]    in_target,
	input  logic [WORD_W-1:0]    in_sensed,
	input  logic [DT_W-1:0]      in_step_time,
	output logic [WORD_W-1:0]    drive,
	output logic                 skipped
);

	localparam logic [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	function automatic logic [WORD_W-1:0] abs_w(input logic [WORD_W-1:0] x);
		abs_w = x[WORD_W-1] ? (~x + 1'b1) : x;
	endfunction

	// magnitude already shifted; saturate and apply sign
	function automatic logic [WORD_W-1:0] sat_mag(input logic [MAG_W-1:0] m, input logic neg);
		logic [WORD_W-1:0] lim;
		logic [WORD_W-1:0] mag;
		lim = neg ? W_MIN : W_MAX;
		if (|m[MAG_W-1:WORD_W] || (m[WORD_W-1:0] > lim)) mag = lim;
		else mag = m[WORD_W-1:0];
		sat_mag = neg ? (~mag + 1'b1) : mag;
	endfunction

	function automatic logic [WORD_W-1:0] sat_sub(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1]) sat_sub = s[WORD_W] ? W_MIN : W_MAX;
		else sat_sub = s[WORD_W-1:0];
	endfunction

	logic [WORD_W-1:0] gp_q, gi_q, gd_q, lim_lo_q, lim_hi_q;
	logic              typ_q;
	logic [WORD_W-1:0] tgt_q, sns_q;
	logic [DT_W-1:0]   dt_q;
	logic [ACC_W-1:0]  ei_q;
	logic [WORD_W-1:0] last_q;
	logic [WORD_W-1:0] err_q, diff_q, p_q, i_q, iraw_q, t_q, d_q;
	logic [PROD_W-1:0] prod_q, lo_prod_q;
	logic              neg_q;
	logic              bc_need_q;
	logic [WORD_W-1:0]    rem_q, den_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 qneg_q;
	logic [WORD_W-1:0] drive_q;
	logic              skipped_q;

	logic [ACC_W-1:0]  ei_mag;
	logic [WORD_W-1:0] mul_a, mul_b;
	logic              mul_neg;
	logic [WIDE_W-1:0] i_full;
	logic [ACC_W-1:0]  inc_ext, inc_val, bc_ext;
	logic [ACC_W:0]    acc_sum;
	logic [WORD_W:0]   trial, trial_sub;
	logic              trial_ge;
	logic [WORD_W+1:0] sum_ext, lo_ext, hi_ext, sum_c1, sum_c2;
	logic [MAG_W-1:0]  prod_mag, quo_mag;

	assign ei_mag = ei_q[ACC_W-1] ? (~ei_q + 1'b1) : ei_q;

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = neg_q;
		case (cmd.op)
			OP_MUL_P: begin
				mul_a   = abs_w(gp_q);
				mul_b   = abs_w(err_q);
				mul_neg = gp_q[WORD_W-1] ^ err_q[WORD_W-1];
			end
			OP_MUL_E: begin
				mul_a   = abs_w(err_q);
				mul_b   = {{(WORD_W-DT_W){1'b0}}, dt_q};
				mul_neg = err_q[WORD_W-1];
			end
			OP_MUL_IL: begin
				mul_a   = abs_w(gi_q);
				mul_b   = ei_mag[WORD_W-1:0];
				mul_neg = gi_q[WORD_W-1] ^ ei_q[ACC_W-1];
			end
			OP_MUL_IH: begin
				mul_a   = abs_w(gi_q);
				mul_b   = ei_mag[ACC_W-1:WORD_W];
				mul_neg = gi_q[WORD_W-1] ^ ei_q[ACC_W-1];
			end
			OP_MUL_D: begin
				mul_a   = abs_w(gd_q);
				mul_b   = abs_w(diff_q);
				mul_neg = gd_q[WORD_W-1] ^ diff_q[WORD_W-1];
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign prod_mag = {{(MAG_W-PROD_W+FRAC_W){1'b0}}, prod_q[PROD_W-1:FRAC_W]};
	assign quo_mag  = {{(MAG_W-DIV_W){1'b0}}, quo_q};
	assign i_full   = {prod_q, {WORD_W{1'b0}}} + {{WORD_W{1'b0}}, lo_prod_q};

	assign inc_ext = {{(ACC_W-PROD_W+DT_FRAC){1'b0}}, prod_q[PROD_W-1:DT_FRAC]};
	assign inc_val = neg_q ? (~inc_ext + 1'b1) : inc_ext;
	assign acc_sum = {ei_q[ACC_W-1], ei_q} + {inc_val[ACC_W-1], inc_val};
	assign bc_ext  = {{(ACC_W-DIV_W){1'b0}}, quo_q};

	assign trial     = {rem_q, quo_q[DIV_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign trial_ge  = trial >= {1'b0, den_q};

	assign sum_ext = {{2{p_q[WORD_W-1]}}, p_q} + {{2{i_q[WORD_W-1]}}, i_q}
		+ {{2{d_q[WORD_W-1]}}, d_q};
	assign lo_ext  = {{2{lim_lo_q[WORD_W-1]}}, lim_lo_q};
	assign hi_ext  = {{2{lim_hi_q[WORD_W-1]}}, lim_hi_q};
	assign sum_c1  = ($signed(sum_ext) > $signed(hi_ext)) ? hi_ext : sum_ext;
	assign sum_c2  = ($signed(sum_c1) < $signed(lo_ext)) ? lo_ext : sum_c1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q     <= '0;
			gi_q     <= '0;
			gd_q     <= '0;
			lim_lo_q <= W_MIN;
			lim_hi_q <= W_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN_P:     gp_q     <= cfg_data;
				CFG_GAIN_I:     gi_q     <= cfg_data;
				CFG_GAIN_D:     gd_q     <= cfg_data;
				CFG_LIMIT_LOW:  lim_lo_q <= cfg_data;
				CFG_LIMIT_HIGH: lim_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ei_q      <= '0;
			last_q    <= '0;
			bc_need_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			case (cmd.op)
				OP_CLEAR: begin
					ei_q   <= '0;
					last_q <= '0;
				end
				OP_ACC: begin
					if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
						ei_q <= {acc_sum[ACC_W], {(ACC_W-1){~acc_sum[ACC_W]}}};
					else
						ei_q <= acc_sum[ACC_W-1:0];
				end
				OP_ICLAMP: begin
					cnt_q <= '0;
					if ($signed(iraw_q) > $signed(lim_hi_q) ||
							$signed(iraw_q) < $signed(lim_lo_q))
						bc_need_q <= |gi_q;
					else
						bc_need_q <= 1'b0;
				end
				OP_DLOAD: cnt_q <= '0;
				OP_DIV:   cnt_q <= cnt_q + 1'b1;
				OP_BC_WB: ei_q <= qneg_q ? (~bc_ext + 1'b1) : bc_ext;
				OP_D:     last_q <= err_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				typ_q <= in_req_type;
				tgt_q <= in_target;
				sns_q <= in_sensed;
				dt_q  <= in_step_time;
			end
			OP_ERR: err_q <= sat_sub(tgt_q, sns_q);
			OP_MUL_P, OP_MUL_E, OP_MUL_IL, OP_MUL_D: begin
				prod_q <= mul_a * mul_b;
				neg_q  <= mul_neg;
			end
			OP_MUL_IH: begin
				lo_prod_q <= prod_q;
				prod_q    <= mul_a * mul_b;
				neg_q     <= mul_neg;
			end
			OP_P:    p_q    <= sat_mag(prod_mag, neg_q);
			OP_IRAW: iraw_q <= sat_mag(i_full[WIDE_W-1:FRAC_W], neg_q);
			OP_ICLAMP: begin
				rem_q <= '0;
				den_q <= abs_w(gi_q);
				if ($signed(iraw_q) > $signed(lim_hi_q)) begin
					i_q    <= lim_hi_q;
					quo_q  <= {abs_w(lim_hi_q), {FRAC_W{1'b0}}};
					qneg_q <= lim_hi_q[WORD_W-1] ^ gi_q[WORD_W-1];
				end else if ($signed(iraw_q) < $signed(lim_lo_q)) begin
					i_q    <= lim_lo_q;
					quo_q  <= {abs_w(lim_lo_q), {FRAC_W{1'b0}}};
					qneg_q <= lim_lo_q[WORD_W-1] ^ gi_q[WORD_W-1];
				end else begin
					i_q <= iraw_q;
				end
			end
			OP_DIV: begin
				rem_q <= trial_ge ? trial_sub[WORD_W-1:0] : trial[WORD_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], trial_ge};
			end
			OP_DIFF: diff_q <= sat_sub(err_q, last_q);
			OP_T:    t_q    <= sat_mag(prod_mag, neg_q);
			OP_DLOAD: begin
				rem_q  <= '0;
				den_q  <= {{(WORD_W-DT_W){1'b0}}, dt_q};
				quo_q  <= {abs_w(t_q), {DT_FRAC{1'b0}}};
				qneg_q <= t_q[WORD_W-1];
			end
			OP_D: d_q <= sat_mag(quo_mag, qneg_q);
			OP_SUM: begin
				drive_q   <= sum_c2[WORD_W-1:0];
				skipped_q <= 1'b0;
			end
			OP_SKIP: begin
				drive_q   <= '0;
				skipped_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign stat.clear_req = typ_q;
	assign stat.dt_zero   = ~|dt_q;
	assign stat.bc_need   = bc_need_q;
	assign stat.div_done  = cnt_q == DIV_CNT_W'(DIV_W);

	assign drive   = drive_q;
	assign skipped = skipped_q;

endmodule

### rtl/pidaw_ctrl.sv
// Controller: sequences datapath operations for one beat at a time.
module pidaw_ctrl
	import pidaw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_DECODE = 5'd1;
	localparam logic [4:0] ST_ERR    = 5'd2;
	localparam logic [4:0] ST_MULP   = 5'd3;
	localparam logic [4:0] ST_P      = 5'd4;
	localparam logic [4:0] ST_MULE   = 5'd5;
	localparam logic [4:0] ST_ACC    = 5'd6;
	localparam logic [4:0] ST_MULIL  = 5'd7;
	localparam logic [4:0] ST_MULIH  = 5'd8;
	localparam logic [4:0] ST_IRAW   = 5'd9;
	localparam logic [4:0] ST_ICLAMP = 5'd10;
	localparam logic [4:0] ST_BCHK   = 5'd11;
	localparam logic [4:0] ST_BDIV   = 5'd12;
	localparam logic [4:0] ST_BCWB   = 5'd13;
	localparam logic [4:0] ST_DIFF   = 5'd14;
	localparam logic [4:0] ST_MULD   = 5'd15;
	localparam logic [4:0] ST_T      = 5'd16;
	localparam logic [4:0] ST_DLOAD  = 5'd17;
	localparam logic [4:0] ST_DDIV   = 5'd18;
	localparam logic [4:0] ST_D      = 5'd19;
	localparam logic [4:0] ST_SUM    = 5'd20;
	localparam logic [4:0] ST_SKIP   = 5'd21;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_load;
	logic       out_free;

	assign in_ready = state_q == ST_IDLE;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.clear_req) begin
					cmd.op  = OP_CLEAR;
					state_d = ST_IDLE;
				end else if (stat.dt_zero) begin
					state_d = ST_SKIP;
				end else begin
					state_d = ST_ERR;
				end
			end
			ST_ERR:    begin cmd.op = OP_ERR;    state_d = ST_MULP;   end
			ST_MULP:   begin cmd.op = OP_MUL_P;  state_d = ST_P;      end
			ST_P:      begin cmd.op = OP_P;      state_d = ST_MULE;   end
			ST_MULE:   begin cmd.op = OP_MUL_E;  state_d = ST_ACC;    end
			ST_ACC:    begin cmd.op = OP_ACC;    state_d = ST_MULIL;  end
			ST_MULIL:  begin cmd.op = OP_MUL_IL; state_d = ST_MULIH;  end
			ST_MULIH:  begin cmd.op = OP_MUL_IH; state_d = ST_IRAW;   end
			ST_IRAW:   begin cmd.op = OP_IRAW;   state_d = ST_ICLAMP; end
			ST_ICLAMP: begin cmd.op = OP_ICLAMP; state_d = ST_BCHK;   end
			ST_BCHK: begin
				state_d = stat.bc_need ? ST_BDIV : ST_DIFF;
			end
			ST_BDIV: begin
				if (stat.div_done) state_d = ST_BCWB;
				else cmd.op = OP_DIV;
			end
			ST_BCWB:   begin cmd.op = OP_BC_WB;  state_d = ST_DIFF;   end
			ST_DIFF:   begin cmd.op = OP_DIFF;   state_d = ST_MULD;   end
			ST_MULD:   begin cmd.op = OP_MUL_D;  state_d = ST_T;      end
			ST_T:      begin cmd.op = OP_T;      state_d = ST_DLOAD;  end
			ST_DLOAD:  begin cmd.op = OP_DLOAD;  state_d = ST_DDIV;   end
			ST_DDIV: begin
				if (stat.div_done) state_d = ST_D;
				else cmd.op = OP_DIV;
			end
			ST_D:      begin cmd.op = OP_D;      state_d = ST_SUM;    end
			ST_SUM: begin
				if (out_free) begin
					cmd.op   = OP_SUM;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SKIP: begin
				if (out_free) begin
					cmd.op   = OP_SKIP;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/pid_controller_antiwindup_core.sv
// Top level of the Q16.16 PID core with integral clamping anti-windup.
// One request beat is worked on at a time. A clear beat gives no response;
// a beat with zero step time answers drive 0 with skipped set. A compute
// beat runs the shared 48-step, one-bit-per-cycle divider for the
// derivative division by step time and, when the integral term clamps
// with a nonzero integral gain, for integral back-calculation, and uses
// one shared 32x32 multiplier. A new request is taken while a finished
// response still waits in the output register. The user must make
// configuration writes only while the core is idle; the core itself
// does not enforce this.
module pid_controller_antiwindup_core
	import pidaw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	pidaw_req_if.sink            req,
	pidaw_rsp_if.source          rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pidaw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pidaw_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_req_type  (req.req_type),
		.in_target    (req.target),
		.in_sensed    (req.sensed),
		.in_step_time (req.step_time),
		.drive        (rsp.drive),
		.skipped      (rsp.skipped)
	);

endmodule

### rtl/pidaw_check.sv
// Port-level checks of the PID core and their bind.
module pidaw_check
	import pidaw_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] drive,
	input logic              skipped
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(skipped))
		else $error("response beat changed while stalled");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && skipped |-> drive == '0)
		else $error("skipped response with nonzero drive");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous beat in progress");

	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("response appeared without a beat in progress");

endmodule

bind pid_controller_antiwindup_core pidaw_check u_pidaw_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.drive     (rsp.drive),
	.skipped   (rsp.skipped)
);
